// ===== sv/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants for the tick timer bank with beeper.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int unsigned NUM_TIMERS  = 16;
  localparam int unsigned TIMER_WIDTH = 8;
  localparam int unsigned LOAD_WIDTH  = 16;
  localparam int unsigned MASK_WIDTH  = 16;

  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 4;

  typedef enum logic [2:0] {
    OP_TICK_10MS  = 3'd0,
    OP_TICK_500US = 3'd1,
    OP_TICK_1S    = 3'd2,
    OP_LOAD_TIMER = 3'd3,
    OP_LOAD_AZ    = 3'd4,
    OP_REQ_BEEPS  = 3'd5,
    OP_CLEAR_KEY  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_BEEP_GAP = 2'd1,
    REG_BEEP_LEN = 2'd2,
    REG_AZ_BUZZ  = 2'd3
  } reg_e;

  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_AIR_ZERO = 2'd1;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd5;
  localparam logic [15:0] BEEP_GAP_RST = 16'd50;
  localparam logic [7:0]  BEEP_LEN_RST = 8'd100;
  localparam logic [7:0]  AZ_BUZZ_RST  = 8'd60;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] beep_gap_ticks;
    logic [7:0]  beep_length_half_periods;
    logic [7:0]  air_zero_buzz_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            opcode;
    logic                  key_down;
    logic [1:0]            mode;
    logic [3:0]            timer_index;
    logic [LOAD_WIDTH-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic                  key_pressed;
    logic                  speaker_level;
    logic                  buzzer_active;
    logic [MASK_WIDTH-1:0] timer_expired_mask;
    logic [7:0]            beeps_remaining;
    logic [15:0]           air_zero_remaining;
    logic                  flasher;
  } out_item_t;

endpackage

// ===== sv/ttb_if.sv =====
// ----------------------------------------------------------------------------
// ttb_in_if / ttb_out_if
// Valid/ready item channels for the tick timer bank.
// ----------------------------------------------------------------------------
interface ttb_in_if;
  logic             valid;
  logic             ready;
  ttb_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface ttb_out_if;
  logic              valid;
  logic              ready;
  ttb_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== sv/tick_timer_bank_with_beeper_top.sv =====
// ----------------------------------------------------------------------------
// tick_timer_bank_with_beeper_top
// Event-driven timer bank: key debounce, software timers, beep sequencer,
// buzzer/speaker drive and one-second flasher with air-zero countdown.
// ----------------------------------------------------------------------------
// Each input item is one event (tick, load, beep request or key clear) and
// yields exactly one result item with the state after that event. State is
// updated when the item is accepted; the result is registered into the output
// register, or the skid entry while that is held. An item can be accepted
// every cycle; the two-entry output buffer keeps accepting while one result
// waits, so in_i.ready drops only when two results are pending. The user must
// write configuration registers over APB only while idle; nothing enforces it.
module tick_timer_bank_with_beeper_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  ttb_in_if.sink                             in_i,
  ttb_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ttb_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [ttb_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [ttb_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);

  localparam int unsigned TW = ttb_pkg::TIMER_WIDTH;
  localparam int unsigned NT = ttb_pkg::NUM_TIMERS;

  ttb_pkg::cfg_t cfg;

  ttb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // state
  logic [7:0]    debounce_q, debounce_d;
  logic          key_latch_q, key_latch_d;
  logic [TW-1:0] timer_q [NT];
  logic [TW-1:0] timer_d [NT];
  logic [15:0]   gap_q, gap_d;
  logic [7:0]    beep_q, beep_d;
  logic [7:0]    buzz_q, buzz_d;
  logic          buzz_en_q, buzz_en_d;
  logic          spk_q, spk_d;
  logic          flash_q, flash_d;
  logic [15:0]   az_q, az_d;

  // output buffer
  ttb_pkg::out_item_t out_q, skid_q, res;
  logic               out_valid_q, skid_valid_q;
  logic               accept, take;

  logic [ttb_pkg::LOAD_WIDTH-1:0] load_hi;
  logic [TW-1:0]                  timer_load;
  logic [7:0]                     beep_load;

  assign in_i.ready  = ~skid_valid_q;
  assign accept      = in_i.valid & in_i.ready;
  assign take        = out_o.valid & out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  assign load_hi    = in_i.item.load_value >> TW;
  assign timer_load = (|load_hi) ? {TW{1'b1}} : in_i.item.load_value[TW-1:0];
  assign beep_load  = (|in_i.item.load_value[15:8]) ? 8'hFF : in_i.item.load_value[7:0];

  always_comb begin
    debounce_d  = debounce_q;
    key_latch_d = key_latch_q;
    timer_d     = timer_q;
    gap_d       = gap_q;
    beep_d      = beep_q;
    buzz_d      = buzz_q;
    buzz_en_d   = buzz_en_q;
    spk_d       = spk_q;
    flash_d     = flash_q;
    az_d        = az_q;

    case (in_i.item.opcode)
      ttb_pkg::OP_TICK_10MS: begin
        if (in_i.item.key_down && !key_latch_q && in_i.item.mode == ttb_pkg::MODE_NORMAL) begin
          if (debounce_q != 8'd0) debounce_d = debounce_q - 8'd1;
          else                    key_latch_d = 1'b1;
        end else begin
          debounce_d = cfg.debounce_ticks;
        end
        for (int i = 0; i < NT; i++) begin
          if (timer_q[i] != '0) timer_d[i] = timer_q[i] - TW'(1);
        end
        if (gap_q != 16'd0) begin
          gap_d = gap_q - 16'd1;
        end else if (beep_q != 8'd0) begin
          gap_d     = cfg.beep_gap_ticks;
          buzz_d    = cfg.beep_length_half_periods;
          beep_d    = beep_q - 8'd1;
          buzz_en_d = 1'b1;
        end
      end
      ttb_pkg::OP_TICK_500US: begin
        if (buzz_en_q) begin
          if (buzz_q != 8'd0) begin
            buzz_d = buzz_q - 8'd1;
            spk_d  = ~spk_q;
          end else begin
            spk_d     = 1'b0;
            buzz_en_d = 1'b0;
          end
        end
      end
      ttb_pkg::OP_TICK_1S: begin
        flash_d = ~flash_q;
        if (az_q != 16'd0) begin
          az_d = az_q - 16'd1;
          if (in_i.item.mode == ttb_pkg::MODE_AIR_ZERO) begin
            buzz_d    = cfg.air_zero_buzz_length;
            buzz_en_d = 1'b1;
          end
        end
      end
      ttb_pkg::OP_LOAD_TIMER: begin
        for (int i = 0; i < NT; i++) begin
          if (in_i.item.timer_index == 4'(i)) timer_d[i] = timer_load;
        end
      end
      ttb_pkg::OP_LOAD_AZ:   az_d        = in_i.item.load_value;
      ttb_pkg::OP_REQ_BEEPS: beep_d      = beep_load;
      ttb_pkg::OP_CLEAR_KEY: key_latch_d = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    res                    = '0;
    res.key_pressed        = key_latch_d;
    res.speaker_level      = spk_d;
    res.buzzer_active      = buzz_en_d;
    res.beeps_remaining    = beep_d;
    res.air_zero_remaining = az_d;
    res.flasher            = flash_d;
    for (int i = 0; i < NT; i++) begin
      res.timer_expired_mask[i] = (timer_d[i] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= '0;
      key_latch_q <= 1'b0;
      for (int i = 0; i < NT; i++) timer_q[i] <= '0;
      gap_q       <= '0;
      beep_q      <= '0;
      buzz_q      <= '0;
      buzz_en_q   <= 1'b0;
      spk_q       <= 1'b0;
      flash_q     <= 1'b0;
      az_q        <= '0;
    end else if (accept) begin
      debounce_q  <= debounce_d;
      key_latch_q <= key_latch_d;
      timer_q     <= timer_d;
      gap_q       <= gap_d;
      beep_q      <= beep_d;
      buzz_q      <= buzz_d;
      buzz_en_q   <= buzz_en_d;
      spk_q       <= spk_d;
      flash_q     <= flash_d;
      az_q        <= az_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      if (out_valid_q) skid_valid_q <= 1'b1;
      else             out_valid_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (accept)  out_q <= res;
    end else if (accept) begin
      if (out_valid_q) skid_q <= res;
      else             out_q  <= res;
    end
  end

endmodule

// ===== sv/ttb_regs.sv =====
// ----------------------------------------------------------------------------
// ttb_regs
// APB configuration registers: debounce, beep gap, beep length, air-zero buzz.
// ----------------------------------------------------------------------------
module ttb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ttb_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [ttb_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [ttb_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready,
  output ttb_pkg::cfg_t                      cfg_o
);

  ttb_pkg::cfg_t cfg_q;
  ttb_pkg::reg_e sel;
  logic          wr_en;

  assign pready = 1'b1;
  assign sel    = ttb_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks           <= ttb_pkg::DEBOUNCE_RST;
      cfg_q.beep_gap_ticks           <= ttb_pkg::BEEP_GAP_RST;
      cfg_q.beep_length_half_periods <= ttb_pkg::BEEP_LEN_RST;
      cfg_q.air_zero_buzz_length     <= ttb_pkg::AZ_BUZZ_RST;
    end else if (wr_en) begin
      case (sel)
        ttb_pkg::REG_DEBOUNCE: cfg_q.debounce_ticks <= pwdata[7:0];
        ttb_pkg::REG_BEEP_GAP: cfg_q.beep_gap_ticks <= pwdata[15:0];
        ttb_pkg::REG_BEEP_LEN: cfg_q.beep_length_half_periods <= pwdata[7:0];
        ttb_pkg::REG_AZ_BUZZ:  cfg_q.air_zero_buzz_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      ttb_pkg::REG_DEBOUNCE: prdata = {24'd0, cfg_q.debounce_ticks};
      ttb_pkg::REG_BEEP_GAP: prdata = {16'd0, cfg_q.beep_gap_ticks};
      ttb_pkg::REG_BEEP_LEN: prdata = {24'd0, cfg_q.beep_length_half_periods};
      ttb_pkg::REG_AZ_BUZZ:  prdata = {24'd0, cfg_q.air_zero_buzz_length};
      default:               prdata = '0;
    endcase
  end

endmodule
